FILE: rtl/wavetable_oscillator_interp_macros.svh
// ----------------------------------------------------------------------------
// Wavetable oscillator assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_INTERP_MACROS_SVH
`define WAVETABLE_OSCILLATOR_INTERP_MACROS_SVH

// Same-cycle implication
`define WTO_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define WTO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wto_pkg.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared constants, opcodes, register indexes and controller commands.
// ----------------------------------------------------------------------------
package wto_pkg;

  // Default sizing
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ADDR_W_DEF      = 10;

  // Fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int PHASE_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int TLEN_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Table length after reset
  localparam int TABLE_LEN_RST = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LEN = 1'd1;

  // Opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_PHASE  = 2'd2
  } op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic tbl_wr;
    logic phase_set;
    logic start;
    logic mul_en;
    logic read_en;
    logic interp_en;
    logic gain_en;
    logic out_load;
  } cmd_t;

endpackage

FILE: rtl/wto_in_if.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface wto_in_if #(
  parameter int ADDR_W      = wto_pkg::ADDR_W_DEF,
  parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF
);
  import wto_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [OPCODE_W-1:0]           opcode;
  logic [ADDR_W-1:0]             table_address;
  logic signed [SAMPLE_BITS-1:0] table_value;
  logic [PHASE_W-1:0]            phase_value;
  logic [GAIN_W-1:0]             envelope_gain;

  modport source (
    output valid, opcode, table_address, table_value, phase_value, envelope_gain,
    input  ready
  );

  modport sink (
    input  valid, opcode, table_address, table_value, phase_value, envelope_gain,
    output ready
  );

endinterface

FILE: rtl/wto_out_if.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator sample channel
// Valid/ready channel carrying one output sample word.
// ----------------------------------------------------------------------------
interface wto_out_if #(
  parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF
);

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (
    output valid, sample_out,
    input  ready
  );

  modport sink (
    input  valid, sample_out,
    output ready
  );

endinterface

FILE: rtl/wto_ctrl.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator controller
// One-hot sequencer for the sample path and output word handshake.
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_interp_macros.svh"

module wto_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [wto_pkg::OPCODE_W-1:0]  opcode_i,
  output logic                          in_ready_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output wto_pkg::cmd_t                 cmd_o
);
  import wto_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_READ   = 6'b000100,
    ST_INTERP = 6'b001000,
    ST_GAIN   = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(opcode_i))
            OP_SAMPLE: begin
              cmd_o.start = 1'b1;
              state_d     = ST_MUL;
            end
            OP_WRITE: cmd_o.tbl_wr    = 1'b1;
            OP_PHASE: cmd_o.phase_set = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.read_en = 1'b1;
        state_d       = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.interp_en = 1'b1;
        state_d         = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain_en = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        // hold here until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `WTO_ASSERT_NEXT(a_start_mul, clk_i, rst_ni, cmd_o.start, state_q == ST_MUL, "sample did not enter multiply")
  `WTO_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, (state_q == ST_OUT) && !out_free, state_q == ST_OUT, "result lost under stall")
  `WTO_ASSERT_IMPL(a_rose_out, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_OUT, "output valid without a finished sample")
  `WTO_ASSERT_IMPL(a_read_order, clk_i, rst_ni, cmd_o.read_en, $past(cmd_o.mul_en), "table read before position product")

endmodule

FILE: rtl/wto_dp.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator datapath
// Config registers, phase accumulator, wave table and interpolation stages.
// ----------------------------------------------------------------------------
module wto_dp #(
  parameter int TABLE_DEPTH = wto_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF,
  localparam int ADDR_W     = $clog2(TABLE_DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wto_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wto_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wto_pkg::cmd_t                     cmd_i,
  input  logic [wto_pkg::ADDR_W_DEF-1:0]    table_address_i,
  input  logic signed [SAMPLE_BITS-1:0]     table_value_i,
  input  logic [wto_pkg::PHASE_W-1:0]       phase_value_i,
  input  logic [wto_pkg::GAIN_W-1:0]        envelope_gain_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o
);
  import wto_pkg::*;

  localparam int LEN_W   = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W   = PHASE_W + LEN_W;
  localparam int IW      = SAMPLE_BITS + FRAC_W + 2;
  localparam int PW      = SAMPLE_BITS + GAIN_W + 1;
  localparam int LEN_RST = (TABLE_DEPTH < TABLE_LEN_RST) ? TABLE_DEPTH : TABLE_LEN_RST;

  localparam logic signed [IW-1:0] IP_HALF = IW'(1) << (FRAC_W - 1);
  localparam logic signed [PW-1:0] G_HALF  = PW'(1) << (GAIN_W - 2);
  localparam logic signed [PW-1:0] S_MAX   = {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] S_MIN   = {{(PW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic [PHASE_W-1:0]            phase_inc_q;
  logic [TLEN_W-1:0]             len_raw;
  logic [LEN_W-1:0]              len_q, len_eff;
  logic [PHASE_W-1:0]            phase_q;
  logic [GAIN_W-1:0]             gain_q;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic [ADDR_W-1:0]             idx, nxt;
  logic [LEN_W-1:0]              idx_inc;
  logic [FRAC_W-1:0]             frac_q;
  logic signed [SAMPLE_BITS-1:0] mem_q [TABLE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] a_q, b_q;
  logic                          addr_ok;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_W:0]        frac_s;
  logic signed [IW-1:0]          ip_mul, a_sh, ip_sum, ip_res;
  logic signed [SAMPLE_BITS-1:0] interp_q;
  logic signed [PW-1:0]          prod_q, prod_d, rnd, shr, sat;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  // Table length is clamped when written
  assign len_raw = cfg_data_i[TLEN_W-1:0];
  always_comb begin
    if (32'(len_raw) < 32'd2) begin
      len_eff = LEN_W'(2);
    end else if (32'(len_raw) > 32'(TABLE_DEPTH)) begin
      len_eff = LEN_W'(TABLE_DEPTH);
    end else begin
      len_eff = LEN_W'(len_raw);
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      len_q       <= LEN_W'(LEN_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PHASE_INC: phase_inc_q <= cfg_data_i[PHASE_W-1:0];
        REG_TABLE_LEN: len_q       <= len_eff;
        default: ;
      endcase
    end
  end

  // Phase accumulator: load on set phase, advance when a sample leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_i.phase_set) begin
      phase_q <= phase_value_i;
    end else if (cmd_i.out_load) begin
      phase_q <= phase_q + phase_inc_q;
    end
  end

  // Position product: integer part is the entry, top fraction bits interpolate
  assign pos_d   = phase_q * len_q;
  assign idx     = pos_q[PHASE_W +: ADDR_W];
  assign idx_inc = LEN_W'(idx) + LEN_W'(1);
  assign nxt     = (idx_inc == len_q) ? '0 : idx_inc[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      gain_q <= envelope_gain_i;
    end
    if (cmd_i.mul_en) begin
      pos_q <= pos_d;
    end
  end

  // Wave table: one write port, two registered read ports
  assign addr_ok = 32'(table_address_i) < 32'(TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && addr_ok) begin
      mem_q[ADDR_W'(table_address_i)] <= table_value_i;
    end
    if (cmd_i.read_en) begin
      a_q    <= mem_q[idx];
      b_q    <= mem_q[nxt];
      frac_q <= pos_q[PHASE_W-1 -: FRAC_W];
    end
  end

  // Linear interpolation, rounded half up
  assign diff   = (SAMPLE_BITS+1)'(b_q) - (SAMPLE_BITS+1)'(a_q);
  assign frac_s = $signed({1'b0, frac_q});
  assign ip_mul = diff * frac_s;
  assign a_sh   = IW'(a_q) <<< FRAC_W;
  assign ip_sum = a_sh + ip_mul + IP_HALF;
  assign ip_res = ip_sum >>> FRAC_W;

  // Envelope gain product
  assign prod_d = interp_q * $signed({1'b0, gain_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.interp_en) begin
      interp_q <= ip_res[SAMPLE_BITS-1:0];
    end
    if (cmd_i.gain_en) begin
      prod_q <= prod_d;
    end
  end

  // Round, scale back by unity gain and saturate
  assign rnd = prod_q + G_HALF;
  assign shr = rnd >>> (GAIN_W - 1);
  always_comb begin
    sat = shr;
    if (shr > S_MAX) begin
      sat = S_MAX;
    end else if (shr < S_MIN) begin
      sat = S_MIN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sample_q <= sat[SAMPLE_BITS-1:0];
    end
  end

  assign sample_out_o = sample_q;

endmodule

FILE: rtl/wavetable_oscillator_interp.sv
// ----------------------------------------------------------------------------
// Wavetable oscillator with linear interpolation
// Request channel in, sample channel out, plain config write port.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries request words: produce a sample, write a table entry or set
//   the phase. out_o carries one sample word per sample request.
//   cfg_we_i/cfg_idx_i/cfg_data_i write phase_increment (0) and table_length
//   (1); write them only while no request is in flight.
//   Table writes and phase loads keep in_i ready; a new word is taken on the
//   next cycle.
//   A sample request passes from acceptance to a valid output word through
//   position multiply, dual table read, interpolation multiply, gain multiply,
//   then round/saturate into the output register. One sample request is in
//   flight at a time: the sequencer walks the single multiply/read chain and
//   takes a new request only once the last has reached the output register.
//   Reset clears the phase, sets phase_increment to 0 and table_length to 1024
//   (TABLE_DEPTH if smaller); the wave table is not cleared and every entry
//   must be written before a sample reads it.
//   When the receiver stalls the result waits in the output register; table
//   writes and phase loads are still taken, and a following sample holds in
//   its last stage until the output register is free.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp #(
  parameter int TABLE_DEPTH = wto_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wto_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wto_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wto_in_if.sink                         in_i,
  wto_out_if.source                      out_o
);
  import wto_pkg::*;

  cmd_t cmd;

  // Sequencer
  wto_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage
  wto_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .table_address_i (in_i.table_address),
    .table_value_i   (in_i.table_value),
    .phase_value_i   (in_i.phase_value),
    .envelope_gain_i (in_i.envelope_gain),
    .sample_out_o    (out_o.sample_out)
  );

endmodule
